// File: sv/itmq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C transmit message queue.
// No dependencies; compiled first.
package itmq_pkg;

  localparam int BUFFER_BYTES_DEF = 256;
  localparam int MAX_SLOTS_DEF    = 256;

  localparam logic [7:0] SLOT_BYTES_RST  = 8'd16;
  localparam logic [7:0] QUIET_TICKS_RST = 8'd2;

  // config register indexes
  localparam logic CFG_SLOT_BYTES  = 1'b0;
  localparam logic CFG_QUIET_TICKS = 1'b1;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_FORCE  = 3'd1,
    MODE_POLL   = 3'd2,
    MODE_REQ    = 3'd3,
    MODE_STOP   = 3'd4,
    MODE_TICK   = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] msg_addr;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       start_valid;
    logic [7:0] start_addr;
    logic [7:0] start_count;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       busy_res;
    logic       queue_empty;
    logic       status;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic rd_en;    // read slot stores, latch products
    logic exec;     // commit state, load result register
  } ctrl_cmd_t;

endpackage

// File: sv/itmq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result words.
// Depends on itmq_pkg.
interface itmq_in_if import itmq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] msg_addr;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, mode, msg_addr, data_byte, last_byte, input ready);
  modport sink   (input valid, mode, msg_addr, data_byte, last_byte, output ready);
endinterface

interface itmq_out_if import itmq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       start_valid;
  logic [7:0] start_addr;
  logic [7:0] start_count;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       busy_res;
  logic       queue_empty;
  logic       status;

  modport source (output valid, start_valid, start_addr, start_count, tx_valid, tx_byte,
                  busy_res, queue_empty, status, input ready);
  modport sink   (input valid, start_valid, start_addr, start_count, tx_valid, tx_byte,
                  busy_res, queue_empty, status, output ready);
endinterface

// File: sv/itmq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/itmq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the queue: input/result handshakes and datapath commands.
// Depends on itmq_pkg.
module itmq_ctrl import itmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register free this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          in_ready      = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: sv/itmq_dp.sv
`timescale 1ns / 1ps
// Datapath: queue pointers, slot stores, config registers, result register.
// Depends on itmq_pkg and itmq_ram.
module itmq_dp import itmq_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  input  item_t     item,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_wdata,
  output res_t      res
);

  localparam int SW  = $clog2(MAX_SLOTS);
  localparam int HW  = SW + 1;
  localparam int DAW = $clog2(BUFFER_BYTES);
  localparam int PW  = HW + 8;
  localparam int BBW = $clog2(BUFFER_BYTES + 1);
  localparam int CW  = (PW + 1 > BBW) ? PW + 1 : BBW;

  // config
  logic [7:0] slot_bytes_r, quiet_ticks_r;

  // item
  item_t item_r;
  mode_t mode;

  // queue state
  logic [HW-1:0]        tail_r, tail_nxt, head_r, head_nxt;
  logic [7:0]           send_off_r, send_off_nxt, load_off_r, load_off_nxt;
  logic                 in_xfer_r, in_xfer_nxt, bus_rdy_r, bus_rdy_nxt;
  logic [7:0]           quiet_cnt_r, quiet_cnt_nxt;
  logic [MAX_SLOTS-1:0] len_vld_r;
  logic [PW-1:0]        head_prod, tail_prod, head_prod_r, tail_prod_r;
  res_t                 res_r, res_nxt;

  // store ports
  logic           head_ok;
  logic [SW-1:0]  rd_slot;
  logic [DAW-1:0] rd_daddr, data_waddr;
  logic           data_we, slot_we, len_we, clr_len;
  logic [SW-1:0]  slot_waddr;
  logic [7:0]     len_wdata;
  logic [7:0]     data_q, tgt_q, len_q, len_rd;

  // exec temporaries
  logic           clr_pend, full, wrote, done, same_slot, drain;
  logic [HW-1:0]  t_idx, h_eff, head_inc;
  logic [7:0]     lo_off;
  logic [PW-1:0]  t_prod;
  logic [8:0]     q_inc;

  assign mode = mode_t'(item_r.mode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_bytes_r  <= SLOT_BYTES_RST;
      quiet_ticks_r <= QUIET_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOT_BYTES:  slot_bytes_r  <= cfg_wdata;
        CFG_QUIET_TICKS: quiet_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= item;
    end
    if (cmd.rd_en) begin
      head_prod_r <= head_prod;
      tail_prod_r <= tail_prod;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  // read side: slot index and byte address of the head message
  assign head_ok   = head_r < HW'(MAX_SLOTS);
  assign rd_slot   = head_ok ? head_r[SW-1:0] : '0;
  assign head_prod = PW'(head_r) * PW'(slot_bytes_r);
  assign tail_prod = PW'(tail_r) * PW'(slot_bytes_r);
  assign rd_daddr  = DAW'(head_prod + PW'(send_off_r));

  itmq_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_data_ram (
    .clk, .we(cmd.exec && data_we), .waddr(data_waddr), .wdata(item_r.data_byte),
    .re(cmd.rd_en), .raddr(rd_daddr), .rdata(data_q)
  );

  itmq_ram #(.WIDTH(8), .DEPTH(MAX_SLOTS)) u_tgt_ram (
    .clk, .we(cmd.exec && slot_we), .waddr(slot_waddr), .wdata(item_r.msg_addr),
    .re(cmd.rd_en), .raddr(rd_slot), .rdata(tgt_q)
  );

  itmq_ram #(.WIDTH(8), .DEPTH(MAX_SLOTS)) u_len_ram (
    .clk, .we(cmd.exec && len_we), .waddr(slot_waddr), .wdata(len_wdata),
    .re(cmd.rd_en), .raddr(rd_slot), .rdata(len_q)
  );

  // lengths not written since the last clear read as zero
  assign len_rd = len_vld_r[rd_slot] ? len_q : 8'd0;

  always_comb begin
    tail_nxt      = tail_r;
    head_nxt      = head_r;
    send_off_nxt  = send_off_r;
    load_off_nxt  = load_off_r;
    in_xfer_nxt   = in_xfer_r;
    bus_rdy_nxt   = bus_rdy_r;
    quiet_cnt_nxt = quiet_cnt_r;
    res_nxt       = '0;
    data_we       = 1'b0;
    slot_we       = 1'b0;
    len_we        = 1'b0;
    clr_len       = 1'b0;
    data_waddr    = '0;
    slot_waddr    = '0;
    len_wdata     = '0;
    clr_pend      = (mode == MODE_FORCE) && (load_off_r == 8'd0);
    t_idx         = clr_pend ? '0 : tail_r;
    lo_off        = clr_pend ? 8'd0 : load_off_r;
    t_prod        = clr_pend ? '0 : tail_prod_r;
    h_eff         = clr_pend ? '0 : HW'(rd_slot);
    full          = (slot_bytes_r == 8'd0) || (t_idx >= HW'(MAX_SLOTS)) ||
                    (CW'(t_prod) + CW'(slot_bytes_r) > CW'(BUFFER_BYTES));
    same_slot     = h_eff == t_idx;
    wrote         = 1'b0;
    done          = 1'b0;
    head_inc      = head_r + HW'(1);
    drain         = (head_inc >= tail_r) || (head_inc >= HW'(MAX_SLOTS)) ||
                    (slot_bytes_r == 8'd0) ||
                    (CW'(head_prod_r) + CW'(slot_bytes_r) > CW'(BUFFER_BYTES));
    q_inc         = 9'(quiet_cnt_r) + 9'd1;

    unique case (mode) inside
      MODE_APPEND, MODE_FORCE: begin
        if (clr_pend) begin
          tail_nxt     = '0;
          head_nxt     = '0;
          send_off_nxt = 8'd0;
          load_off_nxt = 8'd0;
          clr_len      = 1'b1;
        end
        if (full) begin
          res_nxt.status = 1'b1;
        end else begin
          slot_we    = 1'b1;
          slot_waddr = t_idx[SW-1:0];
          if (lo_off < slot_bytes_r) begin
            data_we      = 1'b1;
            data_waddr   = DAW'(t_prod + PW'(lo_off));
            len_we       = 1'b1;
            len_wdata    = lo_off + 8'd1;
            load_off_nxt = lo_off + 8'd1;
            wrote        = 1'b1;
          end else begin
            res_nxt.status = 1'b1;
          end
          if (item_r.last_byte) begin
            tail_nxt     = t_idx + HW'(1);
            load_off_nxt = 8'd0;
            done         = 1'b1;
          end
        end
        if ((mode == MODE_FORCE) && done) begin
          in_xfer_nxt         = 1'b1;
          res_nxt.start_valid = 1'b1;
          res_nxt.start_addr  = same_slot ? item_r.msg_addr : tgt_q;
          res_nxt.start_count = (same_slot && wrote) ? lo_off + 8'd1 : len_rd;
        end
      end
      MODE_POLL: begin
        if (!in_xfer_r && (tail_r != head_r) && bus_rdy_r) begin
          in_xfer_nxt         = 1'b1;
          res_nxt.start_valid = 1'b1;
          res_nxt.start_addr  = tgt_q;
          res_nxt.start_count = len_rd;
        end
      end
      MODE_REQ: begin
        if (head_ok && (send_off_r < len_rd)) begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = data_q;
          send_off_nxt     = send_off_r + 8'd1;
        end
      end
      MODE_STOP: begin
        in_xfer_nxt  = 1'b0;
        bus_rdy_nxt  = 1'b0;
        send_off_nxt = 8'd0;
        head_nxt     = head_inc;
        if (drain) begin
          tail_nxt     = '0;
          head_nxt     = '0;
          load_off_nxt = 8'd0;
          clr_len      = 1'b1;
        end
      end
      MODE_TICK: begin
        if (!bus_rdy_r) begin
          if (q_inc >= 9'(quiet_ticks_r)) begin
            bus_rdy_nxt   = 1'b1;
            quiet_cnt_nxt = 8'd0;
          end else begin
            quiet_cnt_nxt = q_inc[7:0];
          end
        end
      end
      MODE_CLEAR: begin
        tail_nxt     = '0;
        head_nxt     = '0;
        send_off_nxt = 8'd0;
        load_off_nxt = 8'd0;
        clr_len      = 1'b1;
      end
      default: ;
    endcase

    res_nxt.busy_res    = in_xfer_nxt;
    res_nxt.queue_empty = tail_nxt == head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r      <= '0;
      head_r      <= '0;
      send_off_r  <= 8'd0;
      load_off_r  <= 8'd0;
      in_xfer_r   <= 1'b0;
      bus_rdy_r   <= 1'b1;
      quiet_cnt_r <= 8'd0;
      len_vld_r   <= '0;
    end else if (cmd.exec) begin
      tail_r      <= tail_nxt;
      head_r      <= head_nxt;
      send_off_r  <= send_off_nxt;
      load_off_r  <= load_off_nxt;
      in_xfer_r   <= in_xfer_nxt;
      bus_rdy_r   <= bus_rdy_nxt;
      quiet_cnt_r <= quiet_cnt_nxt;
      // a flushing force word clears and writes its slot in one step
      if (clr_len) begin
        len_vld_r <= len_we ? (MAX_SLOTS'(1) << slot_waddr) : '0;
      end else if (len_we) begin
        len_vld_r[slot_waddr] <= 1'b1;
      end
    end
  end

  assign res = res_r;

endmodule

// File: sv/i2c_tx_message_queue_core.sv
`timescale 1ns / 1ps
// Top level of the I2C master transmit message queue.
// Depends on itmq_pkg, itmq_if, itmq_ram, itmq_ctrl and itmq_dp.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+----------------------------------------------
//  in_ch   | in  | valid/ready        | mode, msg_addr, data_byte, last_byte
//  out_ch  | out | valid/ready        | start_*, tx_*, busy_res, queue_empty, status
//  cfg_*   | in  | cfg_we, no ready   | cfg_index (0 slot_bytes, 1 quiet_ticks), data
//
// Each word passes through a read cycle on the slot stores (data, target and
// length RAMs, registered read port), then an execute cycle that updates the
// queue pointers, writes the stores and loads the result register. The result
// is registered in the execute cycle, from idle or back to back, and a new word
// can be accepted in that cycle while the result register is free.
// Reset (rst_n, synchronous) clears pointers, transfer flags and the slot length
// valid bits directly; no clearing pass runs. The result register holds a
// finished word while out_ch stalls. One more word can be taken and read in the
// meantime; its execute step waits for the result register, and no further
// word is taken until that step completes.
module i2c_tx_message_queue_core import itmq_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itmq_in_if.sink    in_ch,
  itmq_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  item_t     item;
  res_t      res;

  assign item.mode      = in_ch.mode;
  assign item.msg_addr  = in_ch.msg_addr;
  assign item.data_byte = in_ch.data_byte;
  assign item.last_byte = in_ch.last_byte;

  // sequencer: READ then EXEC per word
  itmq_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd
  );

  // queue state, slot RAMs and result register
  itmq_dp #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_SLOTS    (MAX_SLOTS)
  ) u_dp (
    .clk,
    .rst_n,
    .cmd,
    .item,
    .cfg_we,
    .cfg_index,
    .cfg_wdata,
    .res
  );

  assign out_ch.start_valid = res.start_valid;
  assign out_ch.start_addr  = res.start_addr;
  assign out_ch.start_count = res.start_count;
  assign out_ch.tx_valid    = res.tx_valid;
  assign out_ch.tx_byte     = res.tx_byte;
  assign out_ch.busy_res    = res.busy_res;
  assign out_ch.queue_empty = res.queue_empty;
  assign out_ch.status      = res.status;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the I2C transmit message queue: directed rows, then random phases.
// Depends on itmq_pkg, itmq_if and i2c_tx_message_queue_core.
module tb_top;
  import itmq_pkg::*;

  // Mode 7 is not part of the mode enum; the block must ignore it.
  localparam logic [2:0] MODE_NONE = 3'd7;

  localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any accepted word

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  itmq_in_if  in_ch();
  itmq_out_if out_ch();

  i2c_tx_message_queue_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Queue predictor. Mirrors the block's buffer, slot bookkeeping and bus state.
  // ---------------------------------------------------------------------------
  logic [7:0]  slot_size;                    // bytes per slot register
  logic [7:0]  gap_len;                      // quiet ticks register
  logic [7:0]  buf_bytes [BUFFER_BYTES_DEF];
  logic [7:0]  slot_addr [MAX_SLOTS_DEF];
  logic [7:0]  slot_fill [MAX_SLOTS_DEF];
  int unsigned wr_slot;                      // slot being loaded
  int unsigned rd_slot;                      // slot being sent
  int unsigned rd_pos;                       // next byte to send
  int unsigned wr_pos;                       // next byte to load
  bit          xfer_on;                      // transfer running
  bit          line_free;                    // quiet time has passed
  int unsigned gap_cnt;

  res_t        due_results[$];               // result words still to arrive
  int unsigned bad_words = 0;
  int unsigned words_sent = 0;
  bit          calm = 1'b0;                  // last part: no idling anywhere
  bit          long_hold = 1'b0;             // receiver hold-off request

  function automatic int unsigned slot_capacity();
    int unsigned n;
    if (slot_size == 8'd0) return 0;
    n = BUFFER_BYTES_DEF / int'(slot_size);
    return (n > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : n;
  endfunction

  // Drops every pending and partly loaded message. Bus state is untouched.
  function automatic void clear_slots();
    foreach (slot_fill[i]) slot_fill[i] = 8'd0;
    wr_slot = 0;
    rd_slot = 0;
    rd_pos  = 0;
    wr_pos  = 0;
  endfunction

  // Returns 1 when the byte is dropped (queue full or slot full).
  function automatic bit load_slot_byte(input item_t w, output bit committed);
    bit dropped;
    dropped   = 1'b0;
    committed = 1'b0;
    if (wr_slot >= slot_capacity()) return 1'b1;
    if (wr_pos < slot_size) begin
      buf_bytes[wr_slot * slot_size + wr_pos] = w.data_byte;
      wr_pos++;
      slot_fill[wr_slot] = 8'(wr_pos);
    end else begin
      dropped = 1'b1;                // slot full, a last mark still commits
    end
    slot_addr[wr_slot] = w.msg_addr;
    if (w.last_byte) begin
      wr_slot++;
      wr_pos    = 0;
      committed = 1'b1;
    end
    return dropped;
  endfunction

  function automatic void launch_head(inout res_t r);
    int unsigned h;
    h = (rd_slot < MAX_SLOTS_DEF) ? rd_slot : 0;
    xfer_on       = 1'b1;
    r.start_valid = 1'b1;
    r.start_addr  = slot_addr[h];
    r.start_count = slot_fill[h];
  endfunction

  function automatic res_t tx_queue_step(input item_t w);
    res_t r;
    bit   committed;
    r = '0;
    case (w.mode)
      MODE_APPEND: r.status = load_slot_byte(w, committed);
      MODE_FORCE: begin
        // a force word only flushes when no message is half loaded
        if (wr_pos == 0) clear_slots();
        r.status = load_slot_byte(w, committed);
        if (committed) launch_head(r);
      end
      MODE_POLL: begin
        if (!xfer_on && wr_slot != rd_slot && line_free) launch_head(r);
      end
      MODE_REQ: begin
        if (rd_slot < MAX_SLOTS_DEF && rd_pos < slot_fill[rd_slot]) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = buf_bytes[rd_slot * slot_size + rd_pos];
          rd_pos++;
        end
      end
      MODE_STOP: begin
        xfer_on = 1'b0;
        rd_slot++;
        rd_pos  = 0;
        if (rd_slot >= wr_slot || rd_slot >= slot_capacity()) clear_slots();
        line_free = 1'b0;
      end
      MODE_TICK: begin
        if (!line_free) begin
          gap_cnt++;
          if (gap_cnt >= gap_len) begin
            line_free = 1'b1;
            gap_cnt   = 0;
          end
        end
      end
      MODE_CLEAR: clear_slots();
      default: ;
    endcase
    r.busy_res    = xfer_on;
    r.queue_empty = (wr_slot == rd_slot);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t rand_word(input logic [2:0] m);
    item_t w;
    w.mode      = m;
    w.msg_addr  = 8'($urandom_range(0, 255));
    w.data_byte = 8'($urandom_range(0, 255));
    w.last_byte = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Drives one word, holds it until accepted, then records its result word.
  // valid is left high after the word is accepted; the next call drives it again.
  task automatic send_word(input item_t w, input bit typed = 1'b0,
                           input res_t typed_res = '0);
    res_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= w.mode;
    in_ch.msg_addr  <= w.msg_addr;
    in_ch.data_byte <= w.data_byte;
    in_ch.last_byte <= w.last_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = tx_queue_step(w);
    due_results.push_back(typed ? typed_res : r);
    if (w.mode != MODE_NONE) words_sent++;
  endtask

  // Sender goes quiet until every result word is back; the block is then idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers in consecutive cycles, write enable dropped once after.
  task automatic write_regs(input logic [7:0] slot, input logic [7:0] quiet);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLOT_BYTES;
    cfg_wdata <= slot;
    @(posedge clk);
    cfg_index <= CFG_QUIET_TICKS;
    cfg_wdata <= quiet;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slot_size = slot;
    gap_len   = quiet;
  endtask

  // Ticks until the quiet time is over, sometimes one more.
  task automatic settle_bus();
    while (!line_free) send_word(rand_word(MODE_TICK));
    if ($urandom_range(0, 3) == 0) send_word(rand_word(MODE_TICK));
  endtask

  // Mostly short messages; small slots sometimes get one byte too many.
  function automatic int unsigned pick_len();
    if (slot_size <= 8'd8 && $urandom_range(0, 5) == 0) return int'(slot_size) + 1;
    return $urandom_range(1, (slot_size < 8'd6) ? int'(slot_size) : 6);
  endfunction

  task automatic load_message(input logic [2:0] m, input int unsigned len);
    item_t       w;
    logic [7:0]  addr;
    int unsigned i;
    addr = 8'($urandom_range(0, 255));
    for (i = 0; i < len; i++) begin
      w           = rand_word(m);
      w.msg_addr  = addr;
      w.last_byte = (i == len - 1);
      send_word(w);
    end
  endtask

  // Well-formed traffic: load 1..3 messages, then poll, read, stop each one.
  task automatic serve_messages();
    int unsigned lens[3];
    int unsigned n_msg;
    int unsigned i;
    n_msg = $urandom_range(1, 3);
    for (i = 0; i < n_msg; i++) begin
      lens[i] = pick_len();
      load_message(MODE_APPEND, lens[i]);
    end
    for (i = 0; i < n_msg; i++) begin
      send_word(rand_word(MODE_POLL));
      repeat (lens[i] + $urandom_range(0, 1)) send_word(rand_word(MODE_REQ));
      send_word(rand_word(MODE_STOP));
      settle_bus();
    end
  endtask

  task automatic force_message();
    int unsigned len;
    len = pick_len();
    load_message(MODE_FORCE, len);
    repeat (len + $urandom_range(0, 1)) send_word(rand_word(MODE_REQ));
    send_word(rand_word(MODE_STOP));
    settle_bus();
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) send_word(rand_word(3'($urandom_range(0, 7))));
    settle_bus();
  endtask

  // Clear first: slot size must not change under stored messages.
  task automatic run_phase(input logic [7:0] slot, input logic [7:0] quiet,
                           input int unsigned words, input bit hold);
    int unsigned stop_at;
    send_word(rand_word(MODE_CLEAR));
    drain_results();
    write_regs(slot, quiet);
    if (hold) long_hold = 1'b1;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: serve_messages();
        6, 7:             force_message();
        default:          noise_burst();
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: either a register write or a word, optionally with a
  // hand-written result word.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit         regs;
    logic [7:0] slot;
    logic [7:0] quiet;
    item_t      w;
    bit         typed;
    res_t       want;
  } step_row_t;

  step_row_t plan[$];

  function automatic void add_word(input logic [2:0] m, input logic [7:0] a,
                                   input logic [7:0] d, input logic l,
                                   input bit typed = 1'b0, input res_t want = '0);
    step_row_t row;
    row.regs  = 1'b0;
    row.slot  = 8'd0;
    row.quiet = 8'd0;
    row.w     = {m, a, d, l};
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic void add_regs(input logic [7:0] slot, input logic [7:0] quiet);
    step_row_t row;
    row.regs  = 1'b1;
    row.slot  = slot;
    row.quiet = quiet;
    row.w     = '0;
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    // block inputs known from time zero
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SLOT_BYTES;
    cfg_wdata       = 8'd0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_APPEND;
    in_ch.msg_addr  = 8'd0;
    in_ch.data_byte = 8'd0;
    in_ch.last_byte = 1'b0;

    // predictor reset state
    slot_size = SLOT_BYTES_RST;
    gap_len   = QUIET_TICKS_RST;
    foreach (buf_bytes[i]) buf_bytes[i] = 8'd0;
    foreach (slot_addr[i]) slot_addr[i] = 8'd0;
    clear_slots();
    xfer_on   = 1'b0;
    line_free = 1'b1;
    gap_cnt   = 0;

    // result word fields: start_valid, start_addr, start_count, tx_valid,
    // tx_byte, busy_res, queue_empty, status
    add_word(MODE_POLL, 8'h00, 8'h00, 1'b0, 1'b1,      // nothing queued yet
             res_t'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0});
    add_word(MODE_STOP, 8'h00, 8'h00, 1'b0, 1'b1,      // stop with no transfer
             res_t'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0});
    add_word(MODE_TICK, 8'h00, 8'h00, 1'b0);
    add_word(MODE_APPEND, 8'hFF, 8'h00, 1'b0);
    add_word(MODE_APPEND, 8'hFF, 8'hFF, 1'b1);
    add_word(MODE_POLL, 8'h00, 8'h00, 1'b0);           // still in quiet time
    add_word(MODE_TICK, 8'h00, 8'h00, 1'b0);
    add_word(MODE_POLL, 8'h00, 8'h00, 1'b0, 1'b1,
             res_t'{1'b1, 8'hFF, 8'h02, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0});
    add_word(MODE_REQ, 8'h00, 8'h00, 1'b0);
    add_word(MODE_REQ, 8'h00, 8'h00, 1'b0);
    add_word(MODE_REQ, 8'h00, 8'h00, 1'b0, 1'b1,       // read past the length
             res_t'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0});
    add_word(MODE_STOP, 8'h00, 8'h00, 1'b0);           // drains the queue
    add_word(MODE_NONE, 8'hFF, 8'hFF, 1'b1, 1'b1,      // unused mode
             res_t'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0});
    add_word(MODE_FORCE, 8'h00, 8'h5A, 1'b1, 1'b1,     // starts though bus not free
             res_t'{1'b1, 8'h00, 8'h01, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0});
    add_word(MODE_STOP, 8'h00, 8'h00, 1'b0);
    add_word(MODE_APPEND, 8'h33, 8'h11, 1'b0);
    add_word(MODE_CLEAR, 8'h00, 8'h00, 1'b0);          // drops the partial message
    add_regs(8'd255, 8'd0);                            // one slot, zero quiet time
    add_word(MODE_TICK, 8'h00, 8'h00, 1'b0);
    add_word(MODE_APPEND, 8'h01, 8'h01, 1'b1);
    add_word(MODE_APPEND, 8'h02, 8'h02, 1'b1, 1'b1,    // queue full
             res_t'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1});
    add_word(MODE_CLEAR, 8'h00, 8'h00, 1'b0);
    add_regs(8'd1, 8'd2);
    add_word(MODE_APPEND, 8'h80, 8'h01, 1'b0);
    add_word(MODE_APPEND, 8'h81, 8'h02, 1'b1, 1'b1,    // slot full, still commits
             res_t'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1});
    add_word(MODE_POLL, 8'h00, 8'h00, 1'b0, 1'b1,
             res_t'{1'b1, 8'h81, 8'h01, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0});
    add_word(MODE_CLEAR, 8'h00, 8'h00, 1'b0);          // busy survives a clear
    add_regs(8'd0, 8'd2);                              // zero slot size
    add_word(MODE_APPEND, 8'hAA, 8'h55, 1'b1, 1'b1,
             res_t'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1});
    add_word(MODE_STOP, 8'h00, 8'h00, 1'b0, 1'b1,
             res_t'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0});
    add_regs(SLOT_BYTES_RST, QUIET_TICKS_RST);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].regs) begin
        drain_results();
        write_regs(plan[i].slot, plan[i].quiet);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    // random phases; the first one starts with a long receiver hold-off
    run_phase(8'd16, 8'd2, 200, 1'b1);
    run_phase(8'd1, 8'd1, 120, 1'b0);
    run_phase(8'd255, 8'd1, 80, 1'b0);
    run_phase(8'd7, 8'd255, 200, 1'b0);
    calm = 1'b1;
    run_phase(8'($urandom_range(2, 32)), 8'($urandom_range(1, 4)), 100, 1'b0);

    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready bursts, one long hold-off on request, none when calm
  // ---------------------------------------------------------------------------
  initial begin : receiver
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking, oldest due word first
  // ---------------------------------------------------------------------------
  function automatic void cmp_field(input string tag, input logic [7:0] want_v,
                                    input logic [7:0] got_v);
    if (want_v !== got_v) begin
      if (bad_words < 40)
        $display("%0t: %s expected %h actual %h", $time, tag, want_v, got_v);
      bad_words++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    res_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.start_valid, out_ch.start_addr, out_ch.start_count, out_ch.tx_valid,
             out_ch.tx_byte, out_ch.busy_res, out_ch.queue_empty, out_ch.status};
      if (due_results.size() == 0) begin
        if (bad_words < 40)
          $display("%0t: result word expected none actual %h", $time, got);
        bad_words++;
      end else begin
        want = due_results.pop_front();
        cmp_field("start_valid", 8'(want.start_valid), 8'(got.start_valid));
        cmp_field("start_addr", want.start_addr, got.start_addr);
        cmp_field("start_count", want.start_count, got.start_count);
        cmp_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
        cmp_field("tx_byte", want.tx_byte, got.tx_byte);
        cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        cmp_field("queue_empty", 8'(want.queue_empty), 8'(got.queue_empty));
        cmp_field("status", 8'(want.status), 8'(got.status));
      end
    end
  end

  // Watchdog: any accepted word on either side restarts the count.
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
